>>> hdl/csv_field_index_scanner_assert.svh
// ----------------------------------------------------------------------------
// CSV field index scanner assertion macros
// Clocked implication checks used by csv_field_index_scanner.sv.
// ----------------------------------------------------------------------------
`ifndef CSV_FIELD_INDEX_SCANNER_ASSERT_SVH
`define CSV_FIELD_INDEX_SCANNER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define CFIS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is held
`define CFIS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> hdl/cfis_pkg.sv
// ----------------------------------------------------------------------------
// CSV field index scanner package
// Widths, character codes, register indexes, status codes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package cfis_pkg;

    // Width of the internal stream offset and field length counters
    localparam int OFFSET_WIDTH = 32;
    // Width of reported offsets and record index
    localparam int OUT_W        = 32;
    localparam int CNT_W        = 8;
    localparam int STATUS_W     = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;

    // Fixed characters
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_LF = 8'd10;

    // Register reset values
    localparam logic [7:0] QUOTE_RST = 8'd34;
    localparam logic [7:0] DELIM_RST = 8'd44;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUOTE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd2;

    // Record status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HEADER   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNTERM   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Classified word queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } t_cfis_in;

    typedef struct packed {
        logic                has_field;
        logic [OUT_W-1:0]    field_begin;
        logic [OUT_W-1:0]    field_end;
        logic [CNT_W-1:0]    field_index;
        logic [OUT_W-1:0]    record_index;
        logic                record_end;
        logic [CNT_W-1:0]    field_count;
        logic [STATUS_W-1:0] status;
    } t_cfis_res;

    typedef struct packed {
        logic [7:0] quote_char;
        logic [7:0] delim_char;
        logic       has_header;
    } t_cfis_cfg;

    // Byte classification carried from front to back
    typedef struct packed {
        logic eq_quote;
        logic eq_delim;
        logic eq_lf;
        logic eq_cr;
        logic eoi;
    } t_cfis_cls;

    typedef struct packed {
        logic full;
        logic empty;
    } t_cfis_qstat;

endpackage

`default_nettype wire

>>> hdl/cfis_byte_if.sv
// ----------------------------------------------------------------------------
// CSV byte channel
// Valid/ready channel carrying one stream byte and its end-of-input flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfis_byte_if;
    import cfis_pkg::*;

    logic     valid;
    logic     ready;
    t_cfis_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/cfis_res_if.sv
// ----------------------------------------------------------------------------
// CSV result channel
// Valid/ready channel carrying one field or record report.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfis_res_if;
    import cfis_pkg::*;

    logic      valid;
    logic      ready;
    t_cfis_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/cfis_front.sv
// ----------------------------------------------------------------------------
// CSV scanner front end
// Accepts stream bytes and classifies them against the configured characters.
// ----------------------------------------------------------------------------
`default_nettype none

module cfis_front (
    cfis_byte_if.sink             i_byte,
    input  cfis_pkg::t_cfis_cfg   i_cfg,
    input  logic                  i_full,
    output logic                  o_push,
    output cfis_pkg::t_cfis_cls   o_entry
);
    import cfis_pkg::*;

    // Take a word whenever the queue has room
    assign i_byte.ready = !i_full;
    assign o_push       = i_byte.valid && !i_full;

    // Compare the byte against quote, delimiter, LF and CR
    always_comb begin
        o_entry.eq_quote = (i_byte.data.data_byte == i_cfg.quote_char);
        o_entry.eq_delim = (i_byte.data.data_byte == i_cfg.delim_char);
        o_entry.eq_lf    = (i_byte.data.data_byte == CH_LF);
        o_entry.eq_cr    = (i_byte.data.data_byte == CH_CR);
        o_entry.eoi      = i_byte.data.end_of_input;
    end

endmodule

`default_nettype wire

>>> hdl/cfis_queue.sv
// ----------------------------------------------------------------------------
// CSV scanner classification queue
// Short FIFO of classified bytes between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cfis_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  cfis_pkg::t_cfis_cls   i_entry,
    input  logic                  i_pop,
    output cfis_pkg::t_cfis_cls   o_entry,
    output cfis_pkg::t_cfis_qstat o_stat
);
    import cfis_pkg::*;

    t_cfis_cls           r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wptr, n_wptr;
    logic [QPTR_W-1:0]   r_rptr, n_rptr;
    logic [QCNT_W-1:0]   r_count, n_count;

    // Advance pointers and occupancy
    always_comb begin
        n_wptr  = i_push ? r_wptr + QPTR_W'(1) : r_wptr;
        n_rptr  = i_pop  ? r_rptr + QPTR_W'(1) : r_rptr;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    assign o_entry      = r_mem[r_rptr];
    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

`default_nettype wire

>>> hdl/cfis_back.sv
// ----------------------------------------------------------------------------
// CSV scanner back end
// Tracks quote, field and record state per byte and registers each result.
// ----------------------------------------------------------------------------
`default_nettype none

module cfis_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_has_header,
    input  logic                  i_entry_valid,
    input  cfis_pkg::t_cfis_cls   i_entry,
    output logic                  o_pop,
    cfis_res_if.source            o_result
);
    import cfis_pkg::*;

    // Scan state
    logic                    r_in_quote,  n_in_quote;
    logic [OFFSET_WIDTH-1:0] r_offset,    n_offset;
    logic [OFFSET_WIDTH-1:0] r_fbegin,    n_fbegin;
    logic [OFFSET_WIDTH-1:0] r_flen,      n_flen;
    logic                    r_fbq,       n_fbq;
    logic                    r_lbq,       n_lbq;
    logic                    r_only_cr,   n_only_cr;
    logic [CNT_W-1:0]        r_fields,    n_fields;
    logic [OUT_W-1:0]        r_records,   n_records;
    logic [CNT_W-1:0]        r_expected,  n_expected;
    logic                    r_hdr_seen,  n_hdr_seen;

    // Output register
    logic                    r_out_valid;
    t_cfis_res               r_res, n_res;

    logic                    go;
    logic                    is_q, is_d, is_n, ordinary;
    logic                    len_zero, len_max, len_ge2;
    logic                    quote_upd, fbq_upd, lbq_upd, only_cr_upd;
    logic                    close_field, close_rec, unterm, long_field, fe_inc, strip;
    logic                    emit;
    logic [OFFSET_WIDTH-1:0] off_p1, off_m1, fb, fe;
    logic [CNT_W-1:0]        fields_after;
    logic [STATUS_W-1:0]     status;

    // Take the next word when the output register is free or draining
    assign go    = i_entry_valid && (!r_out_valid || o_result.ready);
    assign o_pop = go;

    // Classify against the quote state
    always_comb begin
        is_q     = i_entry.eq_quote;
        is_d     = !is_q && i_entry.eq_delim && !r_in_quote;
        is_n     = !is_q && !is_d && i_entry.eq_lf && !r_in_quote;
        ordinary = !is_d && !is_n;

        len_zero = (r_flen == '0);
        len_max  = (r_flen == '1);
        len_ge2  = (r_flen[OFFSET_WIDTH-1:1] != '0);

        quote_upd   = r_in_quote ^ is_q;
        fbq_upd     = (ordinary && len_zero) ? is_q : r_fbq;
        lbq_upd     = ordinary ? is_q : r_lbq;
        only_cr_upd = ordinary ? (r_only_cr && (i_entry.eq_cr || i_entry.eq_lf))
                               : r_only_cr;
    end

    // Decide field and record closure
    always_comb begin
        close_field = 1'b0;
        close_rec   = 1'b0;
        unterm      = 1'b0;
        long_field  = 1'b0;
        fe_inc      = 1'b0;
        if (is_d) begin
            close_field = 1'b1;
            close_rec   = i_entry.eoi;
            long_field  = len_ge2;
        end else if (is_n) begin
            close_field = !len_zero && !r_only_cr;
            close_rec   = 1'b1;
            long_field  = len_ge2;
        end else if (i_entry.eoi) begin
            close_rec   = 1'b1;
            unterm      = quote_upd;
            close_field = !quote_upd && !len_max && !only_cr_upd;
            long_field  = !len_zero && !len_max;
            fe_inc      = 1'b1;
        end
        strip = long_field && fbq_upd && lbq_upd;
        emit  = close_field || close_rec;
    end

    // Build span, count and status
    always_comb begin
        off_p1 = r_offset + OFFSET_WIDTH'(1);
        off_m1 = r_offset - OFFSET_WIDTH'(1);
        fb     = strip ? r_fbegin + OFFSET_WIDTH'(1) : r_fbegin;
        case ({fe_inc, strip})
            2'b01:   fe = off_m1;
            2'b10:   fe = off_p1;
            default: fe = r_offset;
        endcase

        fields_after = r_fields;
        if (close_field && (r_fields != CNT_MAX)) begin
            fields_after = r_fields + CNT_W'(1);
        end

        if (unterm) begin
            status = ST_UNTERM;
        end else if (fields_after == '0) begin
            status = ST_EMPTY;
        end else if (i_has_header && !r_hdr_seen) begin
            status = ST_HEADER;
        end else if (i_has_header && (fields_after != r_expected)) begin
            status = ST_MISMATCH;
        end else begin
            status = ST_OK;
        end

        n_res              = '0;
        n_res.record_index = r_records;
        if (close_field) begin
            n_res.has_field   = 1'b1;
            n_res.field_begin = OUT_W'(fb);
            n_res.field_end   = OUT_W'(fe);
            n_res.field_index = r_fields;
        end
        if (close_rec) begin
            n_res.record_end  = 1'b1;
            n_res.field_count = fields_after;
            n_res.status      = status;
        end
    end

    // Next scan state
    always_comb begin
        n_in_quote = quote_upd;
        n_offset   = off_p1;
        n_fbegin   = r_fbegin;
        n_flen     = r_flen + OFFSET_WIDTH'(1);
        n_fbq      = fbq_upd;
        n_lbq      = lbq_upd;
        n_only_cr  = only_cr_upd;
        n_fields   = fields_after;
        n_records  = r_records;
        n_expected = r_expected;
        n_hdr_seen = r_hdr_seen;
        if (emit) begin
            n_fbegin  = off_p1;
            n_flen    = '0;
            n_fbq     = 1'b0;
            n_lbq     = 1'b0;
            n_only_cr = 1'b1;
        end
        if (close_rec) begin
            n_fields  = '0;
            n_records = r_records + OUT_W'(1);
            if (status == ST_HEADER) begin
                n_expected = fields_after;
                n_hdr_seen = 1'b1;
            end
        end
        // Drop all stream state at end of input
        if (i_entry.eoi) begin
            n_in_quote = 1'b0;
            n_offset   = '0;
            n_fbegin   = '0;
            n_flen     = '0;
            n_fbq      = 1'b0;
            n_lbq      = 1'b0;
            n_only_cr  = 1'b1;
            n_fields   = '0;
            n_records  = '0;
            n_expected = '0;
            n_hdr_seen = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quote <= 1'b0;
            r_offset   <= '0;
            r_fbegin   <= '0;
            r_flen     <= '0;
            r_fbq      <= 1'b0;
            r_lbq      <= 1'b0;
            r_only_cr  <= 1'b1;
            r_fields   <= '0;
            r_records  <= '0;
            r_expected <= '0;
            r_hdr_seen <= 1'b0;
        end else if (go) begin
            r_in_quote <= n_in_quote;
            r_offset   <= n_offset;
            r_fbegin   <= n_fbegin;
            r_flen     <= n_flen;
            r_fbq      <= n_fbq;
            r_lbq      <= n_lbq;
            r_only_cr  <= n_only_cr;
            r_fields   <= n_fields;
            r_records  <= n_records;
            r_expected <= n_expected;
            r_hdr_seen <= n_hdr_seen;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && emit) begin
            r_res <= n_res;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_res;

endmodule

`default_nettype wire

>>> hdl/csv_field_index_scanner.sv
// ----------------------------------------------------------------------------
// CSV field index scanner
// Splits a CSV byte stream into field spans and record reports.
//
// i_byte carries one stream byte per word with an end-of-input flag; the
// stream offset of each byte counts from zero. o_result carries at most one
// word per byte: a closed field span, a record close with count and status,
// or both. Bytes that close nothing give no result.
// Throughput is one byte per cycle while o_result is not stalled. The front
// compares the byte with the configured characters and writes it into a
// four-entry queue; the back reads one word per cycle from the queue while
// its output register is free or draining, updates the scan state and
// loads the output register. With the queue empty, an accepted byte is
// written into the queue and read by the back, which registers any result.
// When o_result stalls, the back holds its word and the queue fills; i_byte
// drops ready only when all four entries are taken. Reset empties queue
// and output register and restores the scan state and the quote, delimiter
// and header registers. After an end-of-input byte the scan state restarts
// at offset zero; the registers keep their values. The user writes the
// registers via i_cfg_we/i_cfg_idx/i_cfg_data only while idle; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

`include "csv_field_index_scanner_assert.svh"

module csv_field_index_scanner (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    cfis_byte_if.sink                        i_byte,
    cfis_res_if.source                       o_result,
    input  logic                             i_cfg_we,
    input  logic [cfis_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [cfis_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import cfis_pkg::*;

    t_cfis_cfg   r_cfg;
    t_cfis_cls   push_entry, head_entry;
    t_cfis_qstat q_stat;
    logic        push, pop;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.quote_char <= QUOTE_RST;
            r_cfg.delim_char <= DELIM_RST;
            r_cfg.has_header <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_QUOTE:  r_cfg.quote_char <= i_cfg_data[7:0];
                CFG_DELIM:  r_cfg.delim_char <= i_cfg_data[7:0];
                CFG_HEADER: r_cfg.has_header <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    cfis_front u_front (
        .i_byte  (i_byte),
        .i_cfg   (r_cfg),
        .i_full  (q_stat.full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    cfis_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_stat  (q_stat)
    );

    cfis_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_has_header  (r_cfg.has_header),
        .i_entry_valid (!q_stat.empty),
        .i_entry       (head_entry),
        .o_pop         (pop),
        .o_result      (o_result)
    );

    // A non-zero status only comes with a record close
    `CFIS_ASSERT_IMP(a_status_rec, i_clk, i_rst_n, o_result.valid && (o_result.data.status != ST_OK), o_result.data.record_end)
    // Field payload is zero when no field is reported
    `CFIS_ASSERT_IMP(a_nofield_zero, i_clk, i_rst_n, o_result.valid && !o_result.data.has_field, (o_result.data.field_begin == '0) && (o_result.data.field_end == '0) && (o_result.data.field_index == '0))
    // A record with no fields is empty or unterminated
    `CFIS_ASSERT_IMP(a_zero_count, i_clk, i_rst_n, o_result.valid && o_result.data.record_end && (o_result.data.field_count == '0), (o_result.data.status == ST_EMPTY) || (o_result.data.status == ST_UNTERM))
    // An accepted word is queued on the next cycle
    `CFIS_ASSERT_NXT(a_push_held, i_clk, i_rst_n, i_byte.valid && i_byte.ready, !q_stat.empty)

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CSV field index scanner testbench
// Drives byte words into the scanner and checks every result word against a
// behavioural scan of the same stream or a typed report. A short table of
// hand-picked bytes comes first: some rows carry the report typed in, the
// rest are checked against the scan model. Random phases follow, each under
// its own quote, delimiter and header setting. Both channels idle at random.
// ----------------------------------------------------------------------------

module tb;
    import cfis_pkg::*;

    localparam int RUN_LIMIT  = 200000;
    localparam int DRAIN_WAIT = 20;
    localparam int PHASE_LEN  = 40;
    localparam int WIDE_DELIMS = 258;

    typedef struct {
        t_cfis_in  w;
        bit        typed;
        t_cfis_res report;
    } t_table_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    cfis_byte_if byte_if();
    cfis_res_if  res_if();

    csv_field_index_scanner dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (byte_if),
        .o_result   (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow of the registers and of the scan state
    t_cfis_cfg   cfg_shadow;
    logic        in_quote;
    logic [31:0] stream_pos;
    logic [31:0] field_start;
    logic        first_is_quote;
    logic        last_is_quote;
    logic        only_cr;
    logic [7:0]  fields_open;
    logic [31:0] records_closed;
    logic [7:0]  header_count;
    logic        header_done;

    t_cfis_res  pending_reports[$];
    t_table_row directed_rows[$];
    t_cfis_in   record_bytes[$];
    int         mismatches;
    bit         quiet;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin : watchdog
        int n;
        for (n = 0; n < RUN_LIMIT; n++) @(posedge i_clk);
        $display("simulation failed");
        $finish;
    end

    function automatic void clear_scan();
        in_quote       = 1'b0;
        stream_pos     = '0;
        field_start    = '0;
        first_is_quote = 1'b0;
        last_is_quote  = 1'b0;
        only_cr        = 1'b1;
        fields_open    = '0;
        records_closed = '0;
        header_count   = '0;
        header_done    = 1'b0;
    endfunction

    // Advance the scan by one byte; return 1 when the byte closes something
    function automatic bit scan_byte(input t_cfis_in w, output t_cfis_res r);
        logic [31:0] len, flen, fb, fe;
        logic        is_q, is_d, is_n;
        logic        close_f, close_r, unterm;
        logic [7:0]  b;
        logic [7:0]  cnt;
        logic [STATUS_W-1:0] st;
        b       = w.data_byte;
        len     = stream_pos - field_start;
        flen    = '0;
        close_f = 1'b0;
        close_r = 1'b0;
        unterm  = 1'b0;
        is_q = (b == cfg_shadow.quote_char);
        is_d = !is_q && (b == cfg_shadow.delim_char) && !in_quote;
        is_n = !is_q && !is_d && (b == CH_LF) && !in_quote;

        if (is_q) in_quote = !in_quote;

        if (is_d) begin
            flen    = len;
            close_f = 1'b1;
            close_r = w.end_of_input;
        end else if (is_n) begin
            flen    = len;
            close_f = (len != 0) && !only_cr;
            close_r = 1'b1;
        end else begin
            if (len == 0) first_is_quote = is_q;
            last_is_quote = is_q;
            if (b != CH_CR && b != CH_LF) only_cr = 1'b0;
            if (w.end_of_input) begin
                close_r = 1'b1;
                if (in_quote) begin
                    unterm = 1'b1;
                end else begin
                    flen    = len + 32'd1;
                    close_f = (flen != 0) && !only_cr;
                end
            end
        end

        r = '0;
        // Report the field span, stripping a surrounding pair of quotes
        if (close_f) begin
            fb = field_start;
            fe = field_start + flen;
            if (flen >= 2 && first_is_quote && last_is_quote) begin
                fb = fb + 32'd1;
                fe = fe - 32'd1;
            end
            r.has_field   = 1'b1;
            r.field_begin = fb;
            r.field_end   = fe;
            r.field_index = fields_open;
            fields_open    = (fields_open == CNT_MAX) ? CNT_MAX : fields_open + 8'd1;
            field_start    = stream_pos + 32'd1;
            first_is_quote = 1'b0;
            last_is_quote  = 1'b0;
            only_cr        = 1'b1;
        end

        r.record_index = records_closed;

        // Close the record with its count and status
        if (close_r) begin
            cnt = fields_open;
            st  = ST_OK;
            if (unterm) begin
                st = ST_UNTERM;
            end else if (cnt == 0) begin
                st = ST_EMPTY;
            end else if (cfg_shadow.has_header && !header_done) begin
                st           = ST_HEADER;
                header_count = cnt;
                header_done  = 1'b1;
            end else if (cfg_shadow.has_header && cnt != header_count) begin
                st = ST_MISMATCH;
            end
            r.record_end   = 1'b1;
            r.field_count  = cnt;
            r.status       = st;
            records_closed = records_closed + 32'd1;
            fields_open    = '0;
            field_start    = stream_pos + 32'd1;
            first_is_quote = 1'b0;
            last_is_quote  = 1'b0;
            only_cr        = 1'b1;
        end

        stream_pos = stream_pos + 32'd1;
        if (w.end_of_input) clear_scan();
        return close_f || close_r;
    endfunction

    // Offer one byte word and hold it until taken; leave valid high afterwards
    task automatic offer_byte(input t_cfis_in w, input bit typed, input t_cfis_res typed_r);
        t_cfis_res r;
        bit        got;
        if (!quiet && $urandom_range(99) < 3) begin
            byte_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        byte_if.valid <= 1'b1;
        byte_if.data  <= w;
        do @(posedge i_clk); while (!byte_if.ready);
        got = scan_byte(w, r);
        if (typed) pending_reports = {pending_reports, typed_r};
        else if (got) pending_reports = {pending_reports, r};
    endtask

    task automatic offer_plain(input t_cfis_in w);
        offer_byte(w, 1'b0, '0);
    endtask

    // Drop valid and hold until every expected word is out and the queue drains
    task automatic wait_idle();
        byte_if.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] q, input logic [7:0] d, input logic h);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_QUOTE;
        i_cfg_data <= q;
        @(posedge i_clk);
        cfg_shadow.quote_char = q;
        i_cfg_idx  <= CFG_DELIM;
        i_cfg_data <= d;
        @(posedge i_clk);
        cfg_shadow.delim_char = d;
        i_cfg_idx  <= CFG_HEADER;
        i_cfg_data <= {{(CFG_DATA_W-1){1'b0}}, h};
        @(posedge i_clk);
        cfg_shadow.has_header = h;
        i_cfg_we   <= 1'b0;
    endtask

    task automatic add_row(input logic [7:0] b, input logic eoi);
        t_table_row row;
        row.w.data_byte    = b;
        row.w.end_of_input = eoi;
        row.typed          = 1'b0;
        row.report         = '0;
        directed_rows = {directed_rows, row};
    endtask

    task automatic add_typed(input logic [7:0] b, input logic eoi, input logic hf,
                             input logic [31:0] fb, input logic [31:0] fe,
                             input logic [7:0] fi, input logic [31:0] ri, input logic re,
                             input logic [7:0] fc, input logic [STATUS_W-1:0] st);
        t_table_row row;
        row.w.data_byte           = b;
        row.w.end_of_input        = eoi;
        row.typed                 = 1'b1;
        row.report.has_field      = hf;
        row.report.field_begin    = fb;
        row.report.field_end      = fe;
        row.report.field_index    = fi;
        row.report.record_index   = ri;
        row.report.record_end     = re;
        row.report.field_count    = fc;
        row.report.status         = st;
        directed_rows = {directed_rows, row};
    endtask

    task automatic push_byte(input logic [7:0] b, input logic eoi);
        t_cfis_in w;
        w.data_byte    = b;
        w.end_of_input = eoi;
        record_bytes = {record_bytes, w};
    endtask

    // Byte that is neither quote, delimiter nor newline
    function automatic logic [7:0] pick_plain();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == cfg_shadow.quote_char || b == cfg_shadow.delim_char || b == CH_LF);
        return b;
    endfunction

    // Byte for the inside of a quoted field
    function automatic logic [7:0] pick_quoted();
        int c;
        c = $urandom_range(0, 7);
        if (c < 2) return cfg_shadow.delim_char;
        if (c == 2) return CH_LF;
        if (c == 3) return CH_CR;
        return pick_plain();
    endfunction

    // Build one record into record_bytes: mostly well-formed, some noise
    task automatic build_record();
        int kind, nf, i, k, j, term;
        t_cfis_in w;
        record_bytes.delete();
        kind = $urandom_range(0, 15);
        if (kind == 0) begin
            push_byte(CH_LF, 1'b0);
        end else if (kind == 1) begin
            k = $urandom_range(1, 8);
            for (i = 0; i < k; i++)
                push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        end else if (kind == 2) begin
            // Open quote left hanging at end of input
            push_byte(cfg_shadow.quote_char, 1'b0);
            k = $urandom_range(0, 3);
            for (i = 0; i < k; i++) push_byte(pick_quoted(), 1'b0);
            push_byte(pick_plain(), 1'b1);
        end else begin
            nf = $urandom_range(1, 3);
            for (i = 0; i < nf; i++) begin
                k = $urandom_range(0, 9);
                if (k < 2) begin
                    // empty field
                end else if (k < 5) begin
                    push_byte(cfg_shadow.quote_char, 1'b0);
                    for (j = $urandom_range(0, 3); j > 0; j--) push_byte(pick_quoted(), 1'b0);
                    push_byte(cfg_shadow.quote_char, 1'b0);
                end else begin
                    for (j = $urandom_range(1, 4); j > 0; j--) push_byte(pick_plain(), 1'b0);
                end
                if (i < nf - 1) push_byte(cfg_shadow.delim_char, 1'b0);
            end
            term = $urandom_range(0, 9);
            if (term == 0) begin
                if (record_bytes.size() == 0) begin
                    push_byte(pick_plain(), 1'b1);
                end else begin
                    w = record_bytes.pop_back();
                    w.end_of_input = 1'b1;
                    record_bytes = {record_bytes, w};
                end
            end else if (term == 1) begin
                push_byte(CH_CR, 1'b0);
                push_byte(CH_LF, 1'b0);
            end else begin
                push_byte(CH_LF, 1'b0);
            end
        end
    endtask

    // Receiver: stall at random in short bursts
    initial begin : result_ready
        int stall_left;
        stall_left   = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else if (!quiet && $urandom_range(99) < 3) begin
                res_if.ready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_cfis_res want, got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = res_if.data;
            if (pending_reports.size() == 0) begin
                $error("result word with no expectation waiting");
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                if (got.has_field !== want.has_field) begin
                    $error("has_field: expected %0d, got %0d", want.has_field, got.has_field);
                    mismatches++;
                end
                if (got.field_begin !== want.field_begin) begin
                    $error("field_begin: expected %0d, got %0d",
                           want.field_begin, got.field_begin);
                    mismatches++;
                end
                if (got.field_end !== want.field_end) begin
                    $error("field_end: expected %0d, got %0d", want.field_end, got.field_end);
                    mismatches++;
                end
                if (got.field_index !== want.field_index) begin
                    $error("field_index: expected %0d, got %0d",
                           want.field_index, got.field_index);
                    mismatches++;
                end
                if (got.record_index !== want.record_index) begin
                    $error("record_index: expected %0d, got %0d",
                           want.record_index, got.record_index);
                    mismatches++;
                end
                if (got.record_end !== want.record_end) begin
                    $error("record_end: expected %0d, got %0d",
                           want.record_end, got.record_end);
                    mismatches++;
                end
                if (got.field_count !== want.field_count) begin
                    $error("field_count: expected %0d, got %0d",
                           want.field_count, got.field_count);
                    mismatches++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    mismatches++;
                end
            end
        end
    end

    // Main sequence
    initial begin : stimulus
        int phase, sent, i;
        logic [7:0] q, d;
        logic       h;
        t_cfis_in   w;

        mismatches = 0;
        quiet      = 1'b0;
        cfg_shadow.quote_char = QUOTE_RST;
        cfg_shadow.delim_char = DELIM_RST;
        cfg_shadow.has_header = 1'b0;
        clear_scan();

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_QUOTE;
        i_cfg_data    <= '0;
        byte_if.valid <= 1'b0;
        byte_if.data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table under reset settings
        add_row  (8'h61, 1'b0);                                                   // a
        add_typed(DELIM_RST, 1'b0, 1'b1, 32'd0, 32'd1, 8'd0, 32'd0, 1'b0, 8'd0, ST_OK);
        add_row  (QUOTE_RST, 1'b0);
        add_row  (DELIM_RST, 1'b0);                                               // inside quotes
        add_row  (CH_LF, 1'b0);                                                   // inside quotes
        add_row  (QUOTE_RST, 1'b0);
        // quotes stripped
        add_typed(CH_LF, 1'b0, 1'b1, 32'd3, 32'd5, 8'd1, 32'd0, 1'b1, 8'd2, ST_OK);
        add_typed(CH_LF, 1'b0, 1'b0, 32'd0, 32'd0, 8'd0, 32'd1, 1'b1, 8'd0, ST_EMPTY);
        add_row  (CH_CR, 1'b0);
        // CR-only field
        add_typed(CH_LF, 1'b0, 1'b0, 32'd0, 32'd0, 8'd0, 32'd2, 1'b1, 8'd0, ST_EMPTY);
        add_row  (8'hFF, 1'b0);
        // end on plain byte
        add_typed(8'h00, 1'b1, 1'b1, 32'd10, 32'd12, 8'd0, 32'd3, 1'b1, 8'd1, ST_OK);
        add_row  (QUOTE_RST, 1'b0);
        // open quote
        add_typed(8'h78, 1'b1, 1'b0, 32'd0, 32'd0, 8'd0, 32'd0, 1'b1, 8'd0, ST_UNTERM);
        add_row  (8'h79, 1'b0);
        // end on delimiter
        add_typed(DELIM_RST, 1'b1, 1'b1, 32'd0, 32'd1, 8'd0, 32'd0, 1'b1, 8'd1, ST_OK);
        // empty field
        add_typed(DELIM_RST, 1'b0, 1'b1, 32'd0, 32'd0, 8'd0, 32'd0, 1'b0, 8'd0, ST_OK);
        add_row  (QUOTE_RST, 1'b0);
        add_row  (QUOTE_RST, 1'b0);
        add_row  (CH_LF, 1'b0);
        add_row  (8'h80, 1'b0);
        add_row  (8'h7F, 1'b1);
        foreach (directed_rows[i])
            offer_byte(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].report);

        // Random phases, each under its own register setting
        for (phase = 0; phase < 9; phase++) begin
            wait_idle();
            case (phase)
                0: begin q = QUOTE_RST; d = DELIM_RST; h = 1'b1; end
                1: begin q = 8'h00;     d = 8'hFF;     h = 1'b1; end
                2: begin q = 8'hFF;     d = 8'h00;     h = 1'b0; end
                3: begin q = DELIM_RST; d = DELIM_RST; h = 1'b1; end   // quote wins over delimiter
                4: begin q = QUOTE_RST; d = CH_LF;     h = 1'b1; end   // delimiter wins over newline
                5: begin q = CH_LF;     d = 8'h3B;     h = 1'b0; end
                6: begin q = CH_CR;     d = DELIM_RST; h = 1'b1; end
                7: begin
                    q = 8'($urandom_range(0, 255));
                    d = 8'($urandom_range(0, 255));
                    h = 1'($urandom_range(0, 1));
                end
                default: begin q = QUOTE_RST; d = DELIM_RST; h = 1'b0; end
            endcase
            set_config(q, d, h);
            quiet = (phase == 3);
            sent  = 0;
            while (sent < PHASE_LEN) begin
                build_record();
                foreach (record_bytes[i]) offer_plain(record_bytes[i]);
                sent += record_bytes.size();
            end
            // Wide record to saturate field index and count
            if (phase == 8) begin
                w.end_of_input = 1'b0;
                w.data_byte    = DELIM_RST;
                for (i = 0; i < WIDE_DELIMS; i++) offer_plain(w);
                w.data_byte = CH_LF;
                offer_plain(w);
            end
        end
        quiet = 1'b0;

        // Drain and settle
        byte_if.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/cfis_pkg.sv
hdl/cfis_byte_if.sv
hdl/cfis_res_if.sv
hdl/cfis_front.sv
hdl/cfis_queue.sv
hdl/cfis_back.sv
hdl/csv_field_index_scanner.sv
tb/tb.sv
